FILE: design/keypad_setpoint_speed_controller_defines.svh
// assertion macros for the keypad setpoint speed controller
`ifndef KEYPAD_SETPOINT_SPEED_CONTROLLER_DEFINES_SVH
`define KEYPAD_SETPOINT_SPEED_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked on clk and held off during rst
`define KSPC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad controller check failed");

// next-cycle implication, checked on clk and held off during rst
`define KSPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad controller check failed");

`endif

FILE: design/ksc_pkg.sv
// types, constants and helper functions of the keypad setpoint speed controller
package ksc_pkg;

  localparam int KEY_W      = 4;
  localparam int PULSE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int SP_W       = 14;
  localparam int DUTY_W     = 8;
  localparam int MODE_W     = 2;
  localparam int DCNT_W     = 3;
  localparam int DB_W       = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam int SAT_CNT_W  = 14;
  localparam int SCALED_W   = 18;
  localparam int RECIP_W    = 19;
  localparam int RECIP_SH   = 20;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENTRY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd3;

  localparam logic OP_KEY     = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  localparam logic [KEY_W-1:0] KEY_CLEAR  = 4'd12;
  localparam logic [KEY_W-1:0] KEY_COMMIT = 4'd14;
  localparam logic [KEY_W-1:0] KEY_UP100  = 4'd3;
  localparam logic [KEY_W-1:0] KEY_UP10   = 4'd7;
  localparam logic [KEY_W-1:0] KEY_DN10   = 4'd11;
  localparam logic [KEY_W-1:0] KEY_DN100  = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'b1;

  localparam logic [DB_W-1:0] DEADBAND_RST = 10'd20;
  localparam logic [SP_W-1:0] LIMIT_RST    = 14'd9999;
  localparam logic [SP_W-1:0] SP_MAX       = 14'd9999;

  localparam logic [SP_W-1:0] BAND_1 = 14'd2500;
  localparam logic [SP_W-1:0] BAND_2 = 14'd5000;
  localparam logic [SP_W-1:0] BAND_3 = 14'd7500;

  localparam logic [DUTY_W-1:0] DUTY_BAND_0 = 8'd32;
  localparam logic [DUTY_W-1:0] DUTY_BAND_1 = 8'd64;
  localparam logic [DUTY_W-1:0] DUTY_BAND_2 = 8'd128;
  localparam logic [DUTY_W-1:0] DUTY_BAND_3 = 8'd192;
  localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;

  // counts at or above this give more than 65535 rpm
  localparam logic [SAT_CNT_W-1:0] SAT_COUNT = 14'd9831;
  // ceil(2^20 / 3), exact division by 3 for values below 2^19
  localparam logic [RECIP_W-1:0] RECIP_3 = 19'd349526;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] value;
  } digit_t;

  localparam digit_t KEY_DIGIT [16] = '{
    '{1'b1, 4'd1}, '{1'b1, 4'd2}, '{1'b1, 4'd3}, '{1'b0, 4'd0},
    '{1'b1, 4'd4}, '{1'b1, 4'd5}, '{1'b1, 4'd6}, '{1'b0, 4'd0},
    '{1'b1, 4'd7}, '{1'b1, 4'd8}, '{1'b1, 4'd9}, '{1'b0, 4'd0},
    '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b0, 4'd0}, '{1'b0, 4'd0}
  };

  function automatic logic [DUTY_W-1:0] band_duty(input logic [SP_W-1:0] sp);
    logic [DUTY_W-1:0] d;
    if (sp < BAND_1) begin
      d = DUTY_BAND_0;
    end else if (sp < BAND_2) begin
      d = DUTY_BAND_1;
    end else if (sp < BAND_3) begin
      d = DUTY_BAND_2;
    end else begin
      d = DUTY_BAND_3;
    end
    return d;
  endfunction

  function automatic logic signed [SP_W+1:0] step_delta(input logic [KEY_W-1:0] key);
    logic signed [SP_W+1:0] d;
    unique case (key)
      KEY_UP100: d = 16'sd100;
      KEY_UP10:  d = 16'sd10;
      KEY_DN10:  d = -16'sd10;
      default:   d = -16'sd100;
    endcase
    return d;
  endfunction

endpackage

FILE: design/ksc_in_if.sv
// event channel: key press or measurement window
interface ksc_in_if;
  import ksc_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [KEY_W-1:0]   key_code;
  logic [PULSE_W-1:0] pulse_count;

  modport source (output valid, output op, output key_code, output pulse_count,
                  input ready);
  modport sink   (input valid, input op, input key_code, input pulse_count,
                  output ready);
endinterface

FILE: design/ksc_out_if.sv
// result channel: duty, setpoint, speed and entry status
interface ksc_out_if;
  import ksc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty;
  logic [SP_W-1:0]    setpoint;
  logic [SPEED_W-1:0] measured_speed;
  logic [MODE_W-1:0]  mode;
  logic [DCNT_W-1:0]  digits_entered;

  modport source (output valid, output duty, output setpoint, output measured_speed,
                  output mode, output digits_entered, input ready);
  modport sink   (input valid, input duty, input setpoint, input measured_speed,
                  input mode, input digits_entered, output ready);
endinterface

FILE: design/keypad_setpoint_speed_controller.sv
// top level of the keypad setpoint speed controller
// a result is registered in the state registers once its event has passed through the event register
// throughput: one event per cycle while the result side is not stalled; the event register feeds the state update
// rate is set by the registered state update that every event passes through
// reset (synchronous, rst high): idle mode, setpoint 0, duty 0, speed 0,
// deadband 20, setpoint limit 9999, no events held
`include "keypad_setpoint_speed_controller_defines.svh"

module keypad_setpoint_speed_controller import ksc_pkg::*; #(
  parameter int MAX_DIGITS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  ksc_in_if.sink                cmd,
  ksc_out_if.source             status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DB_W-1:0]    deadband;
  logic [SP_W-1:0]    setpoint_limit;

  logic               ev_valid;
  logic               ev_op;
  logic [KEY_W-1:0]   ev_key;
  logic [SPEED_W-1:0] ev_speed;
  logic [SPEED_W-1:0] speed_calc;

  logic               out_valid;
  logic [MODE_W-1:0]  mode_reg;
  logic [SP_W-1:0]    setpoint_reg;
  logic [DCNT_W-1:0]  digit_count;
  logic [SP_W-1:0]    place_value;
  logic [SP_W-1:0]    entry;
  logic [DUTY_W-1:0]  duty_reg;
  logic [SPEED_W-1:0] speed_reg;

  logic [MODE_W-1:0]  mode_next;
  logic [SP_W-1:0]    setpoint_next;
  logic [DCNT_W-1:0]  digit_count_next;
  logic [SP_W-1:0]    place_value_next;
  logic [SP_W-1:0]    entry_next;
  logic [DUTY_W-1:0]  duty_next;

  logic               advance;
  logic               proc;

  digit_t                 dig;
  logic [SP_W-1:0]        lim;
  logic [SP_W-1:0]        sp_base;
  logic [SP_W-1:0]        entry_base;
  logic [SP_W-1:0]        commit_val;
  logic [SP_W+3:0]        acc_sum;
  logic [SP_W+3:0]        entry_sum;
  logic [SP_W+3:0]        place_mul;
  logic signed [SP_W+1:0] target;
  logic [SP_W-1:0]        clamped;
  logic [SPEED_W-1:0]     err;
  logic                   sp_above;

  // handshake: the state registers double as the result register
  assign advance   = !out_valid || status.ready;
  assign proc      = ev_valid && advance;
  assign cmd.ready = !ev_valid || advance;

  ksc_speed #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_speed (
    .pulse_count (cmd.pulse_count),
    .speed       (speed_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband       <= DEADBAND_RST;
      setpoint_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADBAND: deadband       <= cfg_data[DB_W-1:0];
        CFG_LIMIT:    setpoint_limit <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (cmd.ready) begin
      ev_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      ev_op    <= cmd.op;
      ev_key   <= cmd.key_code;
      ev_speed <= speed_calc;
    end
  end

  always_comb begin
    dig        = KEY_DIGIT[ev_key];
    lim        = (setpoint_limit > SP_MAX) ? SP_MAX : setpoint_limit;
    sp_base    = (mode_reg == MODE_RUN) ? '0 : setpoint_reg;
    entry_base = (mode_reg == MODE_RUN) ? '0 : entry;
    acc_sum    = (SP_W+4)'(sp_base) + (SP_W+4)'(place_value) * (SP_W+4)'(dig.value);
    entry_sum  = (SP_W+4)'(entry_base) * (SP_W+4)'(10) + (SP_W+4)'(dig.value);
    place_mul  = (SP_W+4)'(place_value) * (SP_W+4)'(10);
    commit_val = (digit_count != '0) ? entry : setpoint_reg;

    if (ev_key == KEY_COMMIT) begin
      target = signed'({2'b00, commit_val});
    end else begin
      target = signed'({2'b00, setpoint_reg}) + step_delta(ev_key);
    end

    if (target <= 0) begin
      clamped = '0;
    end else if (target[SP_W:0] >= {1'b0, lim}) begin
      clamped = lim;
    end else begin
      clamped = target[SP_W-1:0];
    end

    sp_above = SPEED_W'(setpoint_reg) > ev_speed;
    err      = sp_above ? SPEED_W'(setpoint_reg) - ev_speed
                        : ev_speed - SPEED_W'(setpoint_reg);

    mode_next        = mode_reg;
    setpoint_next    = setpoint_reg;
    digit_count_next = digit_count;
    place_value_next = place_value;
    entry_next       = entry;
    duty_next        = duty_reg;

    if (ev_op == OP_MEASURE) begin
      if (mode_reg == MODE_RUN && err >= SPEED_W'(deadband)) begin
        if (sp_above) begin
          if (duty_reg != DUTY_MAX) duty_next = duty_reg + 1'b1;
        end else begin
          if (duty_reg != '0) duty_next = duty_reg - 1'b1;
        end
      end
    end else if (ev_key == KEY_CLEAR) begin
      mode_next        = MODE_IDLE;
      setpoint_next    = '0;
      digit_count_next = '0;
      place_value_next = SP_W'(1);
      entry_next       = '0;
    end else if (dig.valid) begin
      // a zero digit only counts once an entry has begun
      if (dig.value != '0 || mode_reg == MODE_ENTRY) begin
        mode_next     = MODE_ENTRY;
        setpoint_next = sp_base;
        entry_next    = entry_base;
        if (digit_count < DCNT_W'(MAX_DIGITS)) begin
          digit_count_next = digit_count + 1'b1;
          setpoint_next    = acc_sum[SP_W-1:0];
          entry_next       = entry_sum[SP_W-1:0];
          place_value_next = place_mul[SP_W-1:0];
        end
      end
    end else begin
      // commit or step key: clamp and start running
      mode_next        = MODE_RUN;
      setpoint_next    = clamped;
      digit_count_next = '0;
      place_value_next = SP_W'(1);
      entry_next       = '0;
      duty_next        = band_duty(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      mode_reg     <= MODE_IDLE;
      setpoint_reg <= '0;
      digit_count  <= '0;
      place_value  <= SP_W'(1);
      entry        <= '0;
      duty_reg     <= '0;
      speed_reg    <= '0;
    end else begin
      if (advance) begin
        out_valid <= ev_valid;
      end
      if (proc) begin
        mode_reg     <= mode_next;
        setpoint_reg <= setpoint_next;
        digit_count  <= digit_count_next;
        place_value  <= place_value_next;
        entry        <= entry_next;
        duty_reg     <= duty_next;
        if (ev_op == OP_MEASURE) begin
          speed_reg <= ev_speed;
        end
      end
    end
  end

  assign status.valid          = out_valid;
  assign status.duty           = duty_reg;
  assign status.setpoint       = setpoint_reg;
  assign status.measured_speed = speed_reg;
  assign status.mode           = mode_reg;
  assign status.digits_entered = digit_count;

  `KSPC_ASSERT_IMPL(a_digit_limit, 1'b1, digit_count <= DCNT_W'(MAX_DIGITS))
  `KSPC_ASSERT_IMPL(a_run_no_entry, mode_reg == MODE_RUN, digit_count == '0 && entry == '0)
  `KSPC_ASSERT_IMPL(a_run_sp_max, mode_reg == MODE_RUN, setpoint_reg <= SP_MAX)
  `KSPC_ASSERT_NEXT(a_duty_hold, !proc, $stable(duty_reg) && $stable(setpoint_reg))

endmodule

FILE: design/ksc_speed.sv
// pulse count to rpm: floor(count * 20 / 3), saturated at 65535
module ksc_speed import ksc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [PULSE_W-1:0] pulse_count,
  output logic [SPEED_W-1:0] speed
);

  localparam int EFF_W = (COUNT_WIDTH < PULSE_W) ? COUNT_WIDTH : PULSE_W;
  localparam int EXT_W = (EFF_W > SAT_CNT_W) ? EFF_W : SAT_CNT_W;

  logic [EXT_W-1:0]            cnt;
  logic                        sat;
  logic [SAT_CNT_W-1:0]        base;
  logic [SCALED_W-1:0]         scaled;
  logic [SCALED_W+RECIP_W-1:0] prod;

  assign cnt    = EXT_W'(pulse_count[EFF_W-1:0]);
  assign sat    = cnt >= EXT_W'(SAT_COUNT);
  assign base   = sat ? '0 : cnt[SAT_CNT_W-1:0];
  // 20x as 16x + 4x
  assign scaled = {base, 4'b0000} + {2'b00, base, 2'b00};
  assign prod   = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(RECIP_3);
  assign speed  = sat ? '1 : prod[RECIP_SH+SPEED_W-1:RECIP_SH];

endmodule

FILE: verif/tb_keypad_setpoint_speed_controller.sv
// testbench for the keypad setpoint speed controller: directed table, then random phases
`timescale 1ns / 1ps

module tb_keypad_setpoint_speed_controller import ksc_pkg::*;;

  localparam int ENTRY_DIGITS   = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 84;
  localparam int NUM_DIRECTED   = 32;

  // digit value of each keypad position, -1 where the key is not a digit
  localparam int KEYPAD_DIGIT [16] = '{1, 2, 3, -1, 4, 5, 6, -1, 7, 8, 9, -1, -1, 0, -1, -1};
  // keypad position of each digit value
  localparam logic [KEY_W-1:0] DIGIT_KEY [10] = '{4'd13, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
                                                   4'd8, 4'd9, 4'd10};
  localparam logic [KEY_W-1:0] STEP_KEYS [4] = '{KEY_UP100, KEY_UP10, KEY_DN10, KEY_DN100};
  localparam logic [PULSE_W-1:0] EDGE_PULSES [4] = '{16'd0, 16'd65535, 16'd9830, 16'd9831};

  localparam logic [DB_W-1:0]       PHASE_DB    [6] = '{10'd0, 10'd1023, 10'd1, 10'd20, 10'd40,
                                                        10'd0};
  localparam logic [CFG_DATA_W-1:0] PHASE_LIMIT [6] = '{14'd9999, 14'd5000, 14'd0, 14'd16383,
                                                        14'd2499, 14'd7600};
  localparam bit                    PHASE_HEAVY [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [SP_W-1:0]    setpoint;
    logic [SPEED_W-1:0] speed;
    logic [MODE_W-1:0]  mode;
    logic [DCNT_W-1:0]  digits;
  } ctl_status_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [KEY_W-1:0]      key;
    logic [PULSE_W-1:0]    pulses;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  pinned;
    ctl_status_t           want;
  } stim_row_t;

  typedef struct packed {
    logic        pinned;
    ctl_status_t want;
  } pinned_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ksc_in_if  cmd_if ();
  ksc_out_if status_if ();

  keypad_setpoint_speed_controller #(
    .MAX_DIGITS (ENTRY_DIGITS),
    .COUNT_WIDTH(PULSE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .status   (status_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // controller model state
  logic [MODE_W-1:0] ctl_mode;
  logic [SP_W-1:0]   ctl_sp;
  logic [DCNT_W-1:0] ctl_digits;
  logic [SP_W-1:0]   ctl_place;
  logic [DUTY_W-1:0] ctl_duty;
  logic [SPEED_W-1:0] ctl_speed;
  logic [DB_W-1:0]   cur_deadband;
  logic [SP_W-1:0]   cur_limit;

  ctl_status_t status_due_q [$];
  pinned_t     pinned_q [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_calm = 0;
  int          recv_calm = 0;
  stim_row_t   directed_rows [NUM_DIRECTED];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic ctl_status_t st(input int duty, input int sp, input int speed,
                                     input logic [MODE_W-1:0] mode, input int digits);
    ctl_status_t s;
    s.duty     = DUTY_W'(duty);
    s.setpoint = SP_W'(sp);
    s.speed    = SPEED_W'(speed);
    s.mode     = mode;
    s.digits   = DCNT_W'(digits);
    return s;
  endfunction

  function automatic stim_row_t evx(input logic op, input logic [KEY_W-1:0] key,
                                    input logic [PULSE_W-1:0] pulses, input ctl_status_t want);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_EVENT;
    r.op     = op;
    r.key    = key;
    r.pulses = pulses;
    r.pinned = 1'b1;
    r.want   = want;
    return r;
  endfunction

  function automatic stim_row_t ev(input logic op, input logic [KEY_W-1:0] key,
                                   input logic [PULSE_W-1:0] pulses);
    stim_row_t r;
    r = evx(op, key, pulses, '0);
    r.pinned = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t wr(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic reset_controller();
    ctl_mode     = MODE_IDLE;
    ctl_sp       = '0;
    ctl_digits   = '0;
    ctl_place    = SP_W'(1);
    ctl_duty     = '0;
    ctl_speed    = '0;
    cur_deadband = DEADBAND_RST;
    cur_limit    = LIMIT_RST;
  endtask

  task automatic advance_controller(input logic op, input logic [KEY_W-1:0] key,
                                    input logic [PULSE_W-1:0] pulses,
                                    output ctl_status_t res);
    int d, v, lim, acc, rev, i, spd, sp_i, err;
    lim = (cur_limit > SP_MAX) ? int'(SP_MAX) : int'(cur_limit);
    if (op == OP_KEY) begin
      d = KEYPAD_DIGIT[key];
      if (key == KEY_CLEAR) begin
        ctl_mode   = MODE_IDLE;
        ctl_sp     = '0;
        ctl_digits = '0;
        ctl_place  = SP_W'(1);
      end else if (d >= 0) begin
        // leading zero outside entry is dropped
        if (d != 0 || ctl_mode == MODE_ENTRY) begin
          if (ctl_mode == MODE_RUN) ctl_sp = '0;
          ctl_mode = MODE_ENTRY;
          if (ctl_digits < ENTRY_DIGITS) begin
            ctl_digits = ctl_digits + 1'b1;
            ctl_sp     = SP_W'(int'(ctl_sp) + int'(ctl_place) * d);
            ctl_place  = SP_W'(int'(ctl_place) * 10);
          end
        end
      end else begin
        v = int'(ctl_sp);
        if (key == KEY_COMMIT) begin
          // entry is held least significant digit first
          if (ctl_digits != 0) begin
            acc = int'(ctl_sp);
            rev = 0;
            for (i = 0; i < int'(ctl_digits); i++) begin
              rev = rev * 10 + acc % 10;
              acc = acc / 10;
            end
            v = rev;
          end
        end else if (key == KEY_UP100) begin
          v = v + 100;
        end else if (key == KEY_UP10) begin
          v = v + 10;
        end else if (key == KEY_DN10) begin
          v = v - 10;
        end else begin
          v = v - 100;
        end
        if (v <= 0) begin
          ctl_sp = '0;
        end else if (v >= lim) begin
          ctl_sp = SP_W'(lim);
        end else begin
          ctl_sp = SP_W'(v);
        end
        ctl_digits = '0;
        ctl_place  = SP_W'(1);
        if (ctl_sp < BAND_1) begin
          ctl_duty = DUTY_BAND_0;
        end else if (ctl_sp < BAND_2) begin
          ctl_duty = DUTY_BAND_1;
        end else if (ctl_sp < BAND_3) begin
          ctl_duty = DUTY_BAND_2;
        end else begin
          ctl_duty = DUTY_BAND_3;
        end
        ctl_mode = MODE_RUN;
      end
    end else begin
      spd = int'(pulses) * 20 / 3;
      if (spd > 65535) spd = 65535;
      ctl_speed = SPEED_W'(spd);
      if (ctl_mode == MODE_RUN) begin
        sp_i = int'(ctl_sp);
        err  = (sp_i > spd) ? sp_i - spd : spd - sp_i;
        if (err >= int'(cur_deadband)) begin
          if (sp_i > spd) begin
            if (ctl_duty != DUTY_MAX) ctl_duty = ctl_duty + 1'b1;
          end else begin
            if (ctl_duty != '0) ctl_duty = ctl_duty - 1'b1;
          end
        end
      end
    end
    res = st(ctl_duty, ctl_sp, ctl_speed, ctl_mode, ctl_digits);
  endtask

  task automatic check_status(input ctl_status_t want, input ctl_status_t got);
    if (got.duty !== want.duty) begin
      $display("%0t duty mismatch: expected %0d, actual %0d", $time, want.duty, got.duty);
      error_count++;
    end
    if (got.setpoint !== want.setpoint) begin
      $display("%0t setpoint mismatch: expected %0d, actual %0d", $time, want.setpoint,
               got.setpoint);
      error_count++;
    end
    if (got.speed !== want.speed) begin
      $display("%0t measured_speed mismatch: expected %0d, actual %0d", $time, want.speed,
               got.speed);
      error_count++;
    end
    if (got.mode !== want.mode) begin
      $display("%0t mode mismatch: expected %0d, actual %0d", $time, want.mode, got.mode);
      error_count++;
    end
    if (got.digits !== want.digits) begin
      $display("%0t digits_entered mismatch: expected %0d, actual %0d", $time, want.digits,
               got.digits);
      error_count++;
    end
  endtask

  // transfer monitor, model update and checking
  always @(posedge clk) begin
    ctl_status_t got, want;
    pinned_t     pin;
    if (rst) begin
      reset_controller();
      idle_cycles <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEADBAND: cur_deadband = cfg_data[DB_W-1:0];
          CFG_LIMIT:    cur_limit    = cfg_data;
          default: ;
        endcase
      end
      if (status_if.valid && status_if.ready) begin
        got = st(status_if.duty, status_if.setpoint, status_if.measured_speed,
                 status_if.mode, status_if.digits_entered);
        if (status_due_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          error_count++;
        end else begin
          check_status(status_due_q.pop_front(), got);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        advance_controller(cmd_if.op, cmd_if.key_code, cmd_if.pulse_count, want);
        pin = pinned_q.pop_front();
        status_due_q.push_back(pin.pinned ? pin.want : want);
      end
      if ((cmd_if.valid && cmd_if.ready) || (status_if.valid && status_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // random wait length, with occasional runs of back-to-back transfers
  task automatic draw_wait(inout int calm, output int n);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, 14);
    end
  endtask

  // result sink with random stalls
  initial begin
    int n;
    status_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      draw_wait(recv_calm, n);
      if (n > 0) begin
        status_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      status_if.ready <= 1'b1;
      do @(posedge clk); while (!(status_if.valid && status_if.ready));
    end
  end

  task automatic send_event(input logic op, input logic [KEY_W-1:0] key,
                            input logic [PULSE_W-1:0] pulses, input logic pinned,
                            input ctl_status_t want);
    int      gap;
    pinned_t pin;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.op          <= op;
    cmd_if.key_code    <= key;
    cmd_if.pulse_count <= pulses;
    cmd_if.valid       <= 1'b1;
    pin.pinned = pinned;
    pin.want   = want;
    pinned_q.push_back(pin);
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
  endtask

  // hold off new events until every result is back
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input bit heavy, input int items);
    int sent, r, len, i, tgt, near_lim, small_lim, full_lim;
    logic [KEY_W-1:0]   key;
    logic [PULSE_W-1:0] pulses;
    sent      = 0;
    near_lim  = heavy ? 30 : 45;
    small_lim = heavy ? 80 : 60;
    full_lim  = heavy ? 95 : 90;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < (heavy ? 15 : 45)) begin
        // digit entry closed by commit or a step key
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) begin
          send_event(OP_KEY, DIGIT_KEY[$urandom_range(0, 9)], PULSE_W'($urandom), 1'b0, '0);
        end
        key = ($urandom_range(0, 3) == 0) ? STEP_KEYS[$urandom_range(0, 3)] : KEY_COMMIT;
        send_event(OP_KEY, key, PULSE_W'($urandom), 1'b0, '0);
        sent += len + 1;
      end else if (r < (heavy ? 22 : 60)) begin
        send_event(OP_KEY, KEY_W'($urandom), PULSE_W'($urandom), 1'b0, '0);
        sent++;
      end else begin
        len = $urandom_range(1, heavy ? 12 : 4);
        for (i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < near_lim) begin
            tgt = int'(ctl_sp) * 3 / 20 + int'($urandom_range(0, 6)) - 3;
            if (tgt < 0) tgt = 0;
            pulses = PULSE_W'(tgt);
          end else if (r < small_lim) begin
            pulses = PULSE_W'($urandom_range(0, 15));
          end else if (r < full_lim) begin
            pulses = PULSE_W'($urandom);
          end else begin
            pulses = EDGE_PULSES[$urandom_range(0, 3)];
          end
          send_event(OP_MEASURE, KEY_W'($urandom), pulses, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    int i, phase;
    logic [DB_W-1:0]       db;
    logic [CFG_DATA_W-1:0] lim;
    bit                    heavy;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DEADBAND;
    cfg_data           <= '0;
    cmd_if.valid       <= 1'b0;
    cmd_if.op          <= OP_KEY;
    cmd_if.key_code    <= '0;
    cmd_if.pulse_count <= '0;

    directed_rows = '{
      evx(OP_MEASURE, 4'd0, 16'd0, st(0, 0, 0, MODE_IDLE, 0)),
      evx(OP_MEASURE, 4'd0, 16'd65535, st(0, 0, 65535, MODE_IDLE, 0)),
      evx(OP_MEASURE, 4'd15, 16'd9830, st(0, 0, 65533, MODE_IDLE, 0)),
      // leading zero is dropped
      evx(OP_KEY, DIGIT_KEY[0], 16'hFFFF, st(0, 0, 65533, MODE_IDLE, 0)),
      // empty commit
      evx(OP_KEY, KEY_COMMIT, 16'd0, st(32, 0, 65533, MODE_RUN, 0)),
      // step below zero floors
      evx(OP_KEY, KEY_DN100, 16'd0, st(32, 0, 65533, MODE_RUN, 0)),
      evx(OP_KEY, KEY_UP100, 16'd0, st(32, 100, 65533, MODE_RUN, 0)),
      ev(OP_KEY, KEY_UP10, 16'd0),
      ev(OP_KEY, KEY_DN10, 16'd0),
      ev(OP_MEASURE, 4'd0, 16'd15),
      // digit in run mode starts a new entry
      ev(OP_KEY, DIGIT_KEY[2], 16'd0),
      ev(OP_KEY, DIGIT_KEY[0], 16'd0),
      ev(OP_KEY, DIGIT_KEY[6], 16'd0),
      ev(OP_KEY, DIGIT_KEY[8], 16'd0),
      // fifth digit is ignored
      ev(OP_KEY, DIGIT_KEY[5], 16'd0),
      ev(OP_KEY, KEY_COMMIT, 16'd0),
      ev(OP_KEY, KEY_CLEAR, 16'd0),
      // limit above 9999 saturates
      wr(CFG_LIMIT, 14'd16383),
      ev(OP_KEY, DIGIT_KEY[9], 16'd0),
      ev(OP_KEY, DIGIT_KEY[9], 16'd0),
      ev(OP_KEY, DIGIT_KEY[9], 16'd0),
      ev(OP_KEY, DIGIT_KEY[9], 16'd0),
      ev(OP_KEY, KEY_COMMIT, 16'd0),
      evx(OP_KEY, KEY_UP100, 16'd0, st(192, 9999, 100, MODE_RUN, 0)),
      // zero deadband with equal values lowers duty
      wr(CFG_DEADBAND, 10'd0),
      wr(CFG_LIMIT, 14'd20),
      ev(OP_KEY, KEY_COMMIT, 16'd0),
      evx(OP_MEASURE, 4'd0, 16'd3, st(31, 20, 20, MODE_RUN, 0)),
      wr(CFG_DEADBAND, 10'd1023),
      wr(CFG_LIMIT, 14'd0),
      evx(OP_KEY, KEY_COMMIT, 16'd0, st(32, 0, 20, MODE_RUN, 0)),
      ev(OP_MEASURE, 4'd0, 16'd200)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i == 0 || directed_rows[i-1].kind == ROW_EVENT) settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_event(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pulses,
                   directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 6) begin
        db    = PHASE_DB[phase];
        lim   = PHASE_LIMIT[phase];
        heavy = PHASE_HEAVY[phase];
      end else begin
        db    = ($urandom_range(0, 3) == 0) ? DB_W'($urandom_range(0, 1023))
                                            : DB_W'($urandom_range(0, 40));
        lim   = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'(16383)
                                            : CFG_DATA_W'($urandom_range(0, 9999));
        heavy = ($urandom_range(0, 2) == 0);
      end
      settle();
      write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
      write_reg(CFG_LIMIT, lim);
      run_phase(heavy, PHASE_ITEMS);
    end

    settle();
    if (error_count == 0 && status_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
